// ===== hw/rtl/dsrp_pkg.sv =====
// Shared types and constants of the dust sensor reply parser.
// No dependencies; used by every module of the block.
`default_nettype none

package dsrp_pkg;

   // Header byte pairs of the sensor's replies
   localparam logic [7:0] ACK_BYTE      = 8'hA5;
   localparam logic [7:0] NACK_BYTE     = 8'h96;
   localparam logic [7:0] DATA_HEAD_0   = 8'h40;
   localparam logic [7:0] DATA_HEAD_1   = 8'h05;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned READING_W    = 16;
   localparam int unsigned RSP_DATA_W   = 40;

   typedef enum logic [2:0] {
      STATUS_ACK      = 3'd0,
      STATUS_NACK     = 3'd1,
      STATUS_DATA     = 3'd2,
      STATUS_CSUM_ERR = 3'd3,
      STATUS_HDR_ERR  = 3'd4
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [READING_W-1:0]   pm_fine;
      logic [READING_W-1:0]   pm_coarse;
      logic [BYTE_W-1:0]      reply_command;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dsrp_parser_core.sv =====
// Reply parser state and the per-byte step logic of the dust sensor parser.
// Depends on dsrp_pkg.
`default_nettype none

module dsrp_parser_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,        // commit this byte
   input  wire logic [dsrp_pkg::BYTE_W-1:0]  rx_byte,
   input  wire logic                         restart,
   output logic                              has_result,
   output dsrp_pkg::result_type              result
);

   typedef enum logic [2:0] {
      POS_FIRST    = 3'd0,
      POS_SECOND   = 3'd1,
      POS_COMMAND  = 3'd2,
      POS_FINE_HI  = 3'd3,
      POS_FINE_LO  = 3'd4,
      POS_COARSE_HI = 3'd5,
      POS_COARSE_LO = 3'd6,
      POS_CHECKSUM = 3'd7
   } pos_type;

   pos_type                            pos_ff, pos_in, pos_now;
   logic [dsrp_pkg::BYTE_W-1:0]        first_ff, first_in;
   logic [dsrp_pkg::BYTE_W-1:0]        sum_ff, sum_in;
   logic [dsrp_pkg::READING_W-1:0]     fine_ff, fine_in;
   logic [dsrp_pkg::READING_W-1:0]     coarse_ff, coarse_in;
   logic [dsrp_pkg::BYTE_W-1:0]        cmd_ff, cmd_in;
   logic [dsrp_pkg::BYTE_W-1:0]        sum_next;

   assign pos_now  = restart ? POS_FIRST : pos_ff;
   assign sum_next = sum_ff + rx_byte;

   always_comb begin
      pos_in     = pos_now;
      first_in   = first_ff;
      sum_in     = sum_ff;
      fine_in    = fine_ff;
      coarse_in  = coarse_ff;
      cmd_in     = cmd_ff;
      has_result = 1'b0;
      result     = '{status: dsrp_pkg::STATUS_HDR_ERR, pm_fine: '0, pm_coarse: '0,
                     reply_command: '0};
      case (pos_now)
         POS_SECOND: begin
            pos_in     = POS_FIRST;
            has_result = 1'b1;
            if (first_ff == dsrp_pkg::ACK_BYTE && rx_byte == dsrp_pkg::ACK_BYTE) begin
               result.status = dsrp_pkg::STATUS_ACK;
            end else if (first_ff == dsrp_pkg::NACK_BYTE &&
                         rx_byte == dsrp_pkg::NACK_BYTE) begin
               result.status = dsrp_pkg::STATUS_NACK;
            end else if (first_ff == dsrp_pkg::DATA_HEAD_0 &&
                         rx_byte == dsrp_pkg::DATA_HEAD_1) begin
               has_result = 1'b0;
               sum_in     = sum_next;
               pos_in     = POS_COMMAND;
            end
         end
         POS_COMMAND: begin
            cmd_in = rx_byte;
            sum_in = sum_next;
            pos_in = POS_FINE_HI;
         end
         POS_FINE_HI: begin
            fine_in = {rx_byte, dsrp_pkg::BYTE_W'(0)};
            sum_in  = sum_next;
            pos_in  = POS_FINE_LO;
         end
         POS_FINE_LO: begin
            fine_in = {fine_ff[dsrp_pkg::READING_W-1:dsrp_pkg::BYTE_W], rx_byte};
            sum_in  = sum_next;
            pos_in  = POS_COARSE_HI;
         end
         POS_COARSE_HI: begin
            coarse_in = {rx_byte, dsrp_pkg::BYTE_W'(0)};
            sum_in    = sum_next;
            pos_in    = POS_COARSE_LO;
         end
         POS_COARSE_LO: begin
            coarse_in = {coarse_ff[dsrp_pkg::READING_W-1:dsrp_pkg::BYTE_W], rx_byte};
            sum_in    = sum_next;
            pos_in    = POS_CHECKSUM;
         end
         POS_CHECKSUM: begin
            pos_in                = POS_FIRST;
            has_result            = 1'b1;
            result.reply_command  = cmd_ff;
            // checksum is the two's complement of the byte sum
            if (dsrp_pkg::BYTE_W'(0) - sum_ff == rx_byte) begin
               result.status    = dsrp_pkg::STATUS_DATA;
               result.pm_fine   = fine_ff;
               result.pm_coarse = coarse_ff;
            end else begin
               result.status    = dsrp_pkg::STATUS_CSUM_ERR;
            end
         end
         default: begin
            first_in = rx_byte;
            sum_in   = rx_byte;
            pos_in   = POS_SECOND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_FIRST;
         first_ff  <= '0;
         sum_ff    <= '0;
         fine_ff   <= '0;
         coarse_ff <= '0;
         cmd_ff    <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         sum_ff    <= sum_in;
         fine_ff   <= fine_in;
         coarse_ff <= coarse_in;
         cmd_ff    <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dsrp_out_reg.sv =====
// Result register of the dust sensor parser, holding one item for the rsp side.
// Depends on dsrp_pkg.
`default_nettype none

module dsrp_out_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire dsrp_pkg::result_type              result,
   output logic                                   can_load,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dsrp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [2:0]                             rsp_tuser
);

   logic                  valid_ff, valid_in;
   dsrp_pkg::result_type  data_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.status;
   assign rsp_tdata  = {data_ff.reply_command, data_ff.pm_coarse, data_ff.pm_fine};

endmodule

`default_nettype wire

// ===== hw/rtl/dust_sensor_response_parser_top.sv =====
// Top level of the dust sensor reply parser: input register, parser core, result register.
// Depends on dsrp_pkg, dsrp_parser_core and dsrp_out_reg.
`default_nettype none

// Parses the sensor's reply bytes, one item per byte. A reply opens with a
// header pair: A5 A5 yields an ack, 96 96 a nack, 40 05 opens a data frame,
// any other pair a header error. A data frame carries a command byte, PM2.5
// high/low, PM10 high/low and a checksum; it yields either the two readings
// with the command byte or a checksum error carrying the command byte.
// req_tuser (restart) drops any partial frame and takes the byte as the
// first byte of a new reply. Throughput is one byte per clock: each byte
// goes through an input register, one compare-and-add step against the
// parser state, and into the result register, so rsp_tvalid rises once
// the result register loads the result of a reply's last byte. Only the result
// register's backpressure stalls the input, and only for bytes that end a
// reply.
module dust_sensor_response_parser_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // input channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  wire logic         req_tuser,   // [0] restart
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata,   // [15:0] pm_fine, [31:16] pm_coarse,
                                          // [39:32] reply_command
   output logic [2:0]        rsp_tuser    // [2:0] status
);

   logic                                in_valid_ff, in_valid_in;
   logic [dsrp_pkg::BYTE_W-1:0]         in_byte_ff;
   logic                                in_restart_ff;
   logic                                has_result;
   logic                                out_can_load;
   logic                                advance;
   dsrp_pkg::result_type                result;

   // Advance the held byte unless it ends a reply and the result slot is full.
   assign advance     = in_valid_ff && (!has_result || out_can_load);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the item payload on accept; hold it while stalled.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser;
      end
   end

   dsrp_parser_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .restart    (in_restart_ff),
      .has_result (has_result),
      .result     (result)
   );

   dsrp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && has_result),
      .result     (result),
      .can_load   (out_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== test/tb_dust_sensor_response_parser_top.sv =====
`timescale 1ns / 100ps
// Testbench of dust_sensor_response_parser_top: streams reply bytes in, predicts
// every reply result, and checks the result channel item by item.
// Depends on dsrp_pkg and the RTL of the parser.

// Where the parser stands inside the current reply
typedef enum logic [3:0] {
   AWAIT_FIRST,
   AWAIT_SECOND,
   AWAIT_COMMAND,
   AWAIT_FINE_HI,
   AWAIT_FINE_LO,
   AWAIT_COARSE_HI,
   AWAIT_COARSE_LO,
   AWAIT_CHECKSUM
} frame_pos_type;

class reply_scoreboard;
   frame_pos_type          position;
   logic [7:0]             head_byte;
   logic [7:0]             byte_sum;
   logic [15:0]            fine_reading;
   logic [15:0]            coarse_reading;
   logic [7:0]             command_byte;
   dsrp_pkg::result_type   expected_replies[$];
   int unsigned            errors;

   function new();
      position       = AWAIT_FIRST;
      head_byte      = '0;
      byte_sum       = '0;
      fine_reading   = '0;
      coarse_reading = '0;
      command_byte   = '0;
      errors         = 0;
   endfunction

   // Advance the parser state by one accepted byte; queue a reply if it ends one.
   function void note_byte(logic [7:0] rx, logic restart);
      dsrp_pkg::result_type reply;
      logic                 produced;
      reply    = '0;
      produced = 1'b0;
      if (restart) position = AWAIT_FIRST;
      case (position)
         AWAIT_SECOND: begin
            position = AWAIT_FIRST;
            produced = 1'b1;
            if (head_byte == dsrp_pkg::ACK_BYTE && rx == dsrp_pkg::ACK_BYTE) begin
               reply.status = dsrp_pkg::STATUS_ACK;
            end else if (head_byte == dsrp_pkg::NACK_BYTE && rx == dsrp_pkg::NACK_BYTE) begin
               reply.status = dsrp_pkg::STATUS_NACK;
            end else if (head_byte == dsrp_pkg::DATA_HEAD_0 &&
                         rx == dsrp_pkg::DATA_HEAD_1) begin
               byte_sum = byte_sum + rx;
               position = AWAIT_COMMAND;
               produced = 1'b0;
            end else begin
               reply.status = dsrp_pkg::STATUS_HDR_ERR;
            end
         end
         AWAIT_COMMAND: begin
            command_byte = rx;
            byte_sum     = byte_sum + rx;
            position     = AWAIT_FINE_HI;
         end
         AWAIT_FINE_HI: begin
            fine_reading = {rx, 8'h00};
            byte_sum     = byte_sum + rx;
            position     = AWAIT_FINE_LO;
         end
         AWAIT_FINE_LO: begin
            fine_reading[7:0] = rx;
            byte_sum          = byte_sum + rx;
            position          = AWAIT_COARSE_HI;
         end
         AWAIT_COARSE_HI: begin
            coarse_reading = {rx, 8'h00};
            byte_sum       = byte_sum + rx;
            position       = AWAIT_COARSE_LO;
         end
         AWAIT_COARSE_LO: begin
            coarse_reading[7:0] = rx;
            byte_sum            = byte_sum + rx;
            position            = AWAIT_CHECKSUM;
         end
         AWAIT_CHECKSUM: begin
            position            = AWAIT_FIRST;
            produced            = 1'b1;
            reply.reply_command = command_byte;
            if (8'(8'd0 - byte_sum) == rx) begin
               reply.status    = dsrp_pkg::STATUS_DATA;
               reply.pm_fine   = fine_reading;
               reply.pm_coarse = coarse_reading;
            end else begin
               reply.status = dsrp_pkg::STATUS_CSUM_ERR;
            end
         end
         default: begin
            head_byte = rx;
            byte_sum  = rx;
            position  = AWAIT_SECOND;
         end
      endcase
      if (produced) expected_replies.push_back(reply);
   endfunction

   // Compare one accepted result item with the oldest queued reply.
   function void check_reply(logic [39:0] data, logic [2:0] status);
      dsrp_pkg::result_type want;
      if (expected_replies.size() == 0) begin
         if (errors < 10)
            $display("unexpected reply: status %0d data %h", status, data);
         errors++;
         return;
      end
      want = expected_replies.pop_front();
      if (status != want.status || data[15:0] != want.pm_fine ||
          data[31:16] != want.pm_coarse || data[39:32] != want.reply_command) begin
         if (errors < 10)
            $display({"reply mismatch: want st %0d fine %h coarse %h cmd %h,",
                      " got st %0d fine %h coarse %h cmd %h"},
                     want.status, want.pm_fine, want.pm_coarse, want.reply_command,
                     status, data[15:0], data[31:16], data[39:32]);
         errors++;
      end
   endfunction

   function int unsigned pending();
      return expected_replies.size();
   endfunction
endclass

module tb_dust_sensor_response_parser_top;

   localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no handshake on either side
   localparam int unsigned DRAIN_CYCLES = 12;    // watch for stray results after the last expected one
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int unsigned HOLD_OFF     = 300;   // receiver stall that backs up the input

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;    // [7:0] rx_byte
   logic          req_tuser;    // [0] restart
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [39:0]   rsp_tdata;    // [15:0] pm_fine, [31:16] pm_coarse, [39:32] reply_command
   logic [2:0]    rsp_tuser;    // [2:0] status

   reply_scoreboard replies;
   int unsigned     items_sent;
   logic            steady;          // no idling on either side while set
   logic            stall_request;   // ask the receiver for its long hold-off
   logic            restart_next;    // force restart on the next reply's first byte
   logic            random_restart;  // sprinkle restart on first bytes at random

   dust_sensor_response_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one byte, idling first now and then, and hold it until it is taken.
   task automatic send_byte(input logic [7:0] rx, input logic restart);
      if (!steady && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      replies.note_byte(rx, restart);
      items_sent++;
   endtask

   // Restart flag for the first byte of a reply: forced, or at random.
   function automatic logic first_restart();
      logic rs;
      rs           = restart_next || (random_restart && $urandom_range(3) == 0);
      restart_next = 1'b0;
      return rs;
   endfunction

   // Two-byte reply: ack, nack, or whatever pair the caller picks.
   task automatic send_pair(input logic [7:0] first, input logic [7:0] second);
      send_byte(first, first_restart());
      send_byte(second, 1'b0);
   endtask

   // Data frame with correct or corrupted checksum; length below 8 cuts it short.
   task automatic send_frame(input logic [7:0] command, input logic [15:0] fine,
                             input logic [15:0] coarse, input logic corrupt,
                             input int unsigned length);
      logic [7:0]  frame [8];
      logic [7:0]  sum;
      int unsigned i;
      frame[0] = dsrp_pkg::DATA_HEAD_0;
      frame[1] = dsrp_pkg::DATA_HEAD_1;
      frame[2] = command;
      frame[3] = fine[15:8];
      frame[4] = fine[7:0];
      frame[5] = coarse[15:8];
      frame[6] = coarse[7:0];
      sum = '0;
      for (i = 0; i < 7; i++) sum = sum + frame[i];
      frame[7] = 8'd0 - sum;
      if (corrupt) frame[7] = frame[7] ^ 8'($urandom_range(255, 1));
      for (i = 0; i < length; i++) send_byte(frame[i], i == 0 ? first_restart() : 1'b0);
   endtask

   // Reading that leans toward the extremes now and then
   function automatic logic [15:0] pick_reading();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Receiver: check each accepted result, then pick tready for the next edge.
   initial begin : receiver
      int unsigned stall_left;
      logic        stall_done;
      stall_left = 0;
      stall_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) replies.check_reply(rsp_tdata, rsp_tuser);
         if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            stall_left = HOLD_OFF;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 16);
         end
      end
   end

   // Watchdog: end the run once no item has moved on either side for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned kind;
      replies        = new();
      items_sent     = 0;
      steady         = 1'b0;
      stall_request  = 1'b0;
      restart_next   = 1'b0;
      random_restart = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ack with restart on its first byte, nack, header error on
      // extreme bytes, full-scale frame, zero frame with bad checksum, and a
      // frame dropped mid-way by a restart.
      restart_next = 1'b1;
      send_pair(dsrp_pkg::ACK_BYTE, dsrp_pkg::ACK_BYTE);
      send_pair(dsrp_pkg::NACK_BYTE, dsrp_pkg::NACK_BYTE);
      send_pair(8'h00, 8'hFF);
      send_frame(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 8);
      send_frame(8'h00, 16'h0000, 16'h0000, 1'b1, 8);
      send_frame(8'h5A, 16'h1234, 16'hABCD, 1'b0, 3);
      restart_next = 1'b1;
      send_pair(dsrp_pkg::ACK_BYTE, dsrp_pkg::ACK_BYTE);

      // Random: mostly well-formed replies with random content, some broken
      // frames, stray header pairs and noise bytes.
      random_restart = 1'b1;
      items_sent     = 0;
      while (items_sent < RANDOM_ITEMS) begin
         steady = (items_sent >= 250 && items_sent < 350);
         if (items_sent >= 100) stall_request = 1'b1;
         kind = $urandom_range(99);
         if (kind < 15) begin
            send_pair(dsrp_pkg::ACK_BYTE, dsrp_pkg::ACK_BYTE);
         end else if (kind < 25) begin
            send_pair(dsrp_pkg::NACK_BYTE, dsrp_pkg::NACK_BYTE);
         end else if (kind < 70) begin
            send_frame(8'($urandom_range(255)), pick_reading(), pick_reading(),
                       $urandom_range(4) == 0, 8);
         end else if (kind < 80) begin
            send_pair(8'($urandom_range(255)), 8'($urandom_range(255)));
         end else if (kind < 90) begin
            // drop a partial frame: the next reply opens with restart
            send_frame(8'($urandom_range(255)), pick_reading(), pick_reading(), 1'b0,
                       $urandom_range(7, 2));
            restart_next = 1'b1;
         end else begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // Drain: wait for every queued reply, then watch for strays.
      while (replies.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (replies.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dsrp_pkg.sv
hw/rtl/dsrp_parser_core.sv
hw/rtl/dsrp_out_reg.sv
hw/rtl/dust_sensor_response_parser_top.sv
test/tb_dust_sensor_response_parser_top.sv
